FILE: rtl/qas_pkg.sv
// shared types and constants of the quick advection stencil block
package qas_pkg;

    localparam int VAL_W     = 32;
    localparam int DIM_W     = 10;
    localparam int CRD_W     = 11;
    localparam int DIFF_W    = 37;
    localparam int SPLIT_W   = 18;
    localparam int OPD_W     = DIFF_W - SPLIT_W;
    localparam int PROD_W    = VAL_W + OPD_W;
    localparam int ACC_W     = 70;
    localparam int RND_SHIFT = 27;
    localparam int INC_W     = ACC_W - RND_SHIFT;
    localparam int SUM_W     = INC_W + 1;
    localparam int MAC_STEPS = 4;
    localparam int APB_AW    = 4;

    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (RND_SHIFT - 1);

    localparam logic [VAL_W-1:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_SWAP   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] REG_COLS   = 2'd0;
    localparam logic [1:0] REG_ROWS   = 2'd1;
    localparam logic [1:0] REG_COEF_X = 2'd2;
    localparam logic [1:0] REG_COEF_Y = 2'd3;

    localparam logic [DIM_W-1:0] COLS_RESET   = 10'd512;
    localparam logic [DIM_W-1:0] ROWS_RESET   = 10'd512;
    localparam logic [VAL_W-1:0] COEF_RESET   = 32'd8388608;
    localparam logic [DIM_W-1:0] DIM_MIN      = 10'd3;

    typedef struct packed {
        logic [1:0]              operation;
        logic [8:0]              row;
        logic [8:0]              col;
        logic signed [VAL_W-1:0] cell_value;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic                    saturated;
        logic                    index_error;
    } t_result;

    typedef struct packed {
        logic [DIM_W-1:0]        cols;
        logic [DIM_W-1:0]        rows;
        logic signed [VAL_W-1:0] coef_x;
        logic signed [VAL_W-1:0] coef_y;
    } t_cfg;

endpackage

FILE: rtl/quick_advection_stencil_2d.sv
// top level: command sequencer and stencil gather around the two-bank grid ram
//
// Commands enter on start/i_cmd and are taken when start is high and busy
// is low. Each command yields exactly one item on o_result, marked by a
// one-cycle o_result_strobe; the receiver cannot hold it off. busy is low
// again in the strobe cycle, so the next command can be taken there.
// Load, swap and out-of-range addresses finish from the execute state;
// read waits for its one registered ram read; update makes seven grid
// reads through the single ram port, one per cycle, then four 32x19 partial
// products on one shared multiplier, then the write of the new cell into
// the inactive bank. The APB port sets grid size and coefficients; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Reset (i_rst_n low, synchronous) restores register defaults
// and selects bank 0; grid contents are not cleared and must be loaded
// before use.
module quick_advection_stencil_2d #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  qas_pkg::t_cmd              i_cmd,
    output logic                       o_result_strobe,
    output qas_pkg::t_result           o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qas_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = 1 + RW + CW;
    localparam int DEPTH = 2 ** AW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_GATHER = 3'd3;
    localparam logic [2:0] S_MAC    = 3'd4;

    localparam logic [2:0] TAP_C   = 3'd0;
    localparam logic [2:0] TAP_W   = 3'd1;
    localparam logic [2:0] TAP_E   = 3'd2;
    localparam logic [2:0] TAP_X3  = 3'd3;
    localparam logic [2:0] TAP_S   = 3'd4;
    localparam logic [2:0] TAP_N   = 3'd5;
    localparam logic [2:0] TAP_Y3  = 3'd6;
    localparam logic [2:0] TAP_END = 3'd7;

    qas_pkg::t_cfg                      w_cfg;
    logic [2:0]                         r_state;
    logic                               r_bank;
    qas_pkg::t_cmd                      r_cmd;
    logic [qas_pkg::CRD_W-1:0]          r_cw, r_ce, r_cx3, r_rs, r_rn, r_ry3;
    logic [2:0]                         r_rd_idx;
    logic [2:0]                         r_tap_idx;
    logic                               r_tap_vld;
    logic signed [qas_pkg::DIFF_W-1:0]  r_dx, r_dy;
    logic signed [qas_pkg::VAL_W-1:0]   r_uc;
    logic                               r_mac_start;
    logic                               r_strobe;
    qas_pkg::t_result                   r_out;

    logic [qas_pkg::DIM_W-1:0]          w_nc, w_nr;
    logic [qas_pkg::CRD_W-1:0]          w_c, w_r, w_ncx, w_nrx;
    logic [qas_pkg::CRD_W-1:0]          w_ce, w_cee, w_cw, w_cww;
    logic [qas_pkg::CRD_W-1:0]          w_rn, w_rnn, w_rs, w_rss;
    logic [qas_pkg::CRD_W-1:0]          w_cp2, w_rp2;
    logic                               w_err, w_pos_x, w_pos_y;
    logic [qas_pkg::CRD_W-1:0]          w_tap_row, w_tap_col;
    logic                               w_mem_we;
    logic [AW-1:0]                      w_mem_addr;
    logic [qas_pkg::VAL_W-1:0]          w_mem_wdata;
    logic [qas_pkg::VAL_W-1:0]          w_mem_rdata;
    logic signed [qas_pkg::DIFF_W-1:0]  w_v1, w_v3, w_v7, w_term_x, w_term_y;
    logic                               w_mac_done;
    logic signed [qas_pkg::INC_W-1:0]   w_inc;
    logic signed [qas_pkg::SUM_W-1:0]   w_sum;
    logic [qas_pkg::SUM_W-1:qas_pkg::VAL_W-1] w_sum_top;
    logic                               w_sat;
    logic [qas_pkg::VAL_W-1:0]          w_new;

    qas_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    qas_ram #(
        .WIDTH (qas_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    qas_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mac_start),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_kx    (w_cfg.coef_x),
        .i_ky    (w_cfg.coef_y),
        .o_done  (w_mac_done),
        .o_inc   (w_inc)
    );

    // effective grid size, clamped to 3..MAX
    always_comb begin
        if (w_cfg.cols < qas_pkg::DIM_MIN) begin
            w_nc = qas_pkg::DIM_MIN;
        end else if (32'(w_cfg.cols) > MAX_COLS) begin
            w_nc = qas_pkg::DIM_W'(MAX_COLS);
        end else begin
            w_nc = w_cfg.cols;
        end
        if (w_cfg.rows < qas_pkg::DIM_MIN) begin
            w_nr = qas_pkg::DIM_MIN;
        end else if (32'(w_cfg.rows) > MAX_ROWS) begin
            w_nr = qas_pkg::DIM_W'(MAX_ROWS);
        end else begin
            w_nr = w_cfg.rows;
        end
    end

    assign w_pos_x = !w_cfg.coef_x[qas_pkg::VAL_W-1] && (w_cfg.coef_x != '0);
    assign w_pos_y = !w_cfg.coef_y[qas_pkg::VAL_W-1] && (w_cfg.coef_y != '0);

    // periodic neighbor coordinates
    always_comb begin
        w_c   = qas_pkg::CRD_W'(r_cmd.col);
        w_r   = qas_pkg::CRD_W'(r_cmd.row);
        w_ncx = qas_pkg::CRD_W'(w_nc);
        w_nrx = qas_pkg::CRD_W'(w_nr);
        w_err = (w_r >= w_nrx) || (w_c >= w_ncx);

        w_ce  = (w_c + 11'd1 == w_ncx) ? '0 : w_c + 11'd1;
        w_cp2 = w_c + 11'd2;
        w_cee = (w_cp2 >= w_ncx) ? w_cp2 - w_ncx : w_cp2;
        w_cw  = (w_c == '0) ? w_ncx - 11'd1 : w_c - 11'd1;
        w_cww = (w_c >= 11'd2) ? w_c - 11'd2 : w_c + w_ncx - 11'd2;

        w_rn  = (w_r + 11'd1 == w_nrx) ? '0 : w_r + 11'd1;
        w_rp2 = w_r + 11'd2;
        w_rnn = (w_rp2 >= w_nrx) ? w_rp2 - w_nrx : w_rp2;
        w_rs  = (w_r == '0) ? w_nrx - 11'd1 : w_r - 11'd1;
        w_rss = (w_r >= 11'd2) ? w_r - 11'd2 : w_r + w_nrx - 11'd2;
    end

    always_comb begin
        w_tap_row = qas_pkg::CRD_W'(r_cmd.row);
        w_tap_col = qas_pkg::CRD_W'(r_cmd.col);
        case (r_rd_idx)
            TAP_W:   w_tap_col = r_cw;
            TAP_E:   w_tap_col = r_ce;
            TAP_X3:  w_tap_col = r_cx3;
            TAP_S:   w_tap_row = r_rs;
            TAP_N:   w_tap_row = r_rn;
            TAP_Y3:  w_tap_row = r_ry3;
            default: ;
        endcase
    end

    // final add and clip
    assign w_sum     = qas_pkg::SUM_W'(r_uc) + qas_pkg::SUM_W'(w_inc);
    assign w_sum_top = w_sum[qas_pkg::SUM_W-1:qas_pkg::VAL_W-1];
    assign w_sat     = !((&w_sum_top) || (~|w_sum_top));
    assign w_new     = w_sat ? (w_sum[qas_pkg::SUM_W-1] ? qas_pkg::SAT_MIN : qas_pkg::SAT_MAX)
                             : w_sum[qas_pkg::VAL_W-1:0];

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_wdata = r_cmd.cell_value;
        w_mem_addr  = {r_bank, RW'(w_tap_row), CW'(w_tap_col)};
        if (r_state == S_EXEC) begin
            w_mem_we   = (r_cmd.operation == qas_pkg::OP_LOAD) && !w_err;
            w_mem_addr = {r_bank, RW'(r_cmd.row), CW'(r_cmd.col)};
        end else if (r_state == S_MAC) begin
            w_mem_we    = w_mac_done;
            w_mem_wdata = w_new;
            w_mem_addr  = {~r_bank, RW'(r_cmd.row), CW'(r_cmd.col)};
        end
    end

    // stencil weights per tap, split by the sign of the coefficient
    assign w_v1 = qas_pkg::DIFF_W'($signed(w_mem_rdata));
    assign w_v3 = (w_v1 <<< 1) + w_v1;
    assign w_v7 = (w_v1 <<< 3) - w_v1;

    always_comb begin
        w_term_x = '0;
        w_term_y = '0;
        case (r_tap_idx)
            TAP_C: begin
                w_term_x = w_pos_x ? -w_v3 : w_v3;
                w_term_y = w_pos_y ? -w_v3 : w_v3;
            end
            TAP_W:   w_term_x = w_pos_x ? w_v7 : w_v3;
            TAP_E:   w_term_x = w_pos_x ? -w_v3 : -w_v7;
            TAP_X3:  w_term_x = w_pos_x ? -w_v1 : w_v1;
            TAP_S:   w_term_y = w_pos_y ? w_v7 : w_v3;
            TAP_N:   w_term_y = w_pos_y ? -w_v3 : -w_v7;
            TAP_Y3:  w_term_y = w_pos_y ? -w_v1 : w_v1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_rd_idx    <= TAP_END;
            r_tap_vld   <= 1'b0;
            r_mac_start <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe    <= 1'b0;
            r_mac_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_cmd.operation == qas_pkg::OP_SWAP) begin
                        r_bank   <= ~r_bank;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (w_err) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_cmd.operation == qas_pkg::OP_LOAD) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_cmd.operation == qas_pkg::OP_READ) begin
                        r_state <= S_RDWAIT;
                    end else begin
                        r_rd_idx  <= TAP_C;
                        r_tap_vld <= 1'b0;
                        r_state   <= S_GATHER;
                    end
                end
                S_RDWAIT: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_GATHER: begin
                    r_tap_vld <= (r_rd_idx != TAP_END);
                    if (r_rd_idx != TAP_END) begin
                        r_rd_idx <= r_rd_idx + 3'd1;
                    end
                    if (r_tap_vld && (r_tap_idx == TAP_Y3)) begin
                        r_tap_vld   <= 1'b0;
                        r_mac_start <= 1'b1;
                        r_state     <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (w_mac_done) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_EXEC) begin
            r_cw  <= w_cw;
            r_ce  <= w_ce;
            r_cx3 <= w_pos_x ? w_cww : w_cee;
            r_rs  <= w_rs;
            r_rn  <= w_rn;
            r_ry3 <= w_pos_y ? w_rss : w_rnn;
            r_dx  <= '0;
            r_dy  <= '0;
            r_out.result_value <= '0;
            r_out.saturated    <= 1'b0;
            r_out.index_error  <= w_err && (r_cmd.operation != qas_pkg::OP_SWAP);
            if (r_cmd.operation == qas_pkg::OP_LOAD && !w_err) begin
                r_out.result_value <= r_cmd.cell_value;
            end
        end
        if (r_state == S_RDWAIT) begin
            r_out.result_value <= w_mem_rdata;
        end
        if (r_state == S_GATHER) begin
            r_tap_idx <= r_rd_idx;
            if (r_tap_vld) begin
                r_dx <= r_dx + w_term_x;
                r_dy <= r_dy + w_term_y;
                if (r_tap_idx == TAP_C) begin
                    r_uc <= w_mem_rdata;
                end
            end
        end
        if (r_state == S_MAC && w_mac_done) begin
            r_out.result_value <= w_new;
            r_out.saturated    <= w_sat;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result        = r_out;

endmodule

FILE: rtl/qas_ram.sv
// generic single-port ram with registered read
module qas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/qas_cfg.sv
// apb register file: grid size and advection coefficients
module qas_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qas_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output qas_pkg::t_cfg              o_cfg
);

    logic [qas_pkg::DIM_W-1:0] r_cols;
    logic [qas_pkg::DIM_W-1:0] r_rows;
    logic [qas_pkg::VAL_W-1:0] r_coef_x;
    logic [qas_pkg::VAL_W-1:0] r_coef_y;
    logic [1:0]                w_idx;
    logic                      w_wr;

    assign w_idx  = paddr[qas_pkg::APB_AW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= qas_pkg::COLS_RESET;
            r_rows   <= qas_pkg::ROWS_RESET;
            r_coef_x <= qas_pkg::COEF_RESET;
            r_coef_y <= qas_pkg::COEF_RESET;
        end else if (w_wr) begin
            case (w_idx)
                qas_pkg::REG_COLS:   r_cols   <= pwdata[qas_pkg::DIM_W-1:0];
                qas_pkg::REG_ROWS:   r_rows   <= pwdata[qas_pkg::DIM_W-1:0];
                qas_pkg::REG_COEF_X: r_coef_x <= pwdata;
                qas_pkg::REG_COEF_Y: r_coef_y <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            qas_pkg::REG_COLS:   prdata = 32'(r_cols);
            qas_pkg::REG_ROWS:   prdata = 32'(r_rows);
            qas_pkg::REG_COEF_X: prdata = r_coef_x;
            qas_pkg::REG_COEF_Y: prdata = r_coef_y;
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.cols   = r_cols;
    assign o_cfg.rows   = r_rows;
    assign o_cfg.coef_x = r_coef_x;
    assign o_cfg.coef_y = r_coef_y;

endmodule

FILE: rtl/qas_mac.sv
// multi-cycle multiply-accumulate: (kx*dx + ky*dy + half) >>> 27
module qas_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [qas_pkg::DIFF_W-1:0]  i_dx,
    input  logic signed [qas_pkg::DIFF_W-1:0]  i_dy,
    input  logic signed [qas_pkg::VAL_W-1:0]   i_kx,
    input  logic signed [qas_pkg::VAL_W-1:0]   i_ky,
    output logic                               o_done,
    output logic signed [qas_pkg::INC_W-1:0]   o_inc
);

    logic                               r_busy;
    logic [2:0]                         r_step;
    logic signed [qas_pkg::PROD_W-1:0]  r_prod;
    logic                               r_prod_vld;
    logic                               r_prod_hi;
    logic signed [qas_pkg::ACC_W-1:0]   r_acc;
    logic                               r_done;
    logic signed [qas_pkg::VAL_W-1:0]   w_k;
    logic signed [qas_pkg::OPD_W-1:0]   w_op;
    logic signed [qas_pkg::ACC_W-1:0]   w_ext;
    logic signed [qas_pkg::ACC_W-1:0]   w_addend;

    // low halves are unsigned, high halves carry the sign
    always_comb begin
        case (r_step)
            3'd0: begin
                w_k  = i_kx;
                w_op = {1'b0, i_dx[qas_pkg::SPLIT_W-1:0]};
            end
            3'd1: begin
                w_k  = i_kx;
                w_op = i_dx[qas_pkg::DIFF_W-1:qas_pkg::SPLIT_W];
            end
            3'd2: begin
                w_k  = i_ky;
                w_op = {1'b0, i_dy[qas_pkg::SPLIT_W-1:0]};
            end
            3'd3: begin
                w_k  = i_ky;
                w_op = i_dy[qas_pkg::DIFF_W-1:qas_pkg::SPLIT_W];
            end
            default: begin
                w_k  = '0;
                w_op = '0;
            end
        endcase
    end

    assign w_ext    = qas_pkg::ACC_W'(r_prod);
    assign w_addend = r_prod_hi ? (w_ext <<< qas_pkg::SPLIT_W) : w_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_step     <= '0;
            r_prod_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy     <= 1'b1;
                r_step     <= '0;
                r_prod_vld <= 1'b0;
            end else if (r_busy) begin
                r_prod_vld <= (r_step < 3'(qas_pkg::MAC_STEPS));
                r_step     <= r_step + 3'd1;
                if (r_step == 3'(qas_pkg::MAC_STEPS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= qas_pkg::ROUND_BIAS;
        end else if (r_busy) begin
            r_prod    <= w_k * w_op;
            r_prod_hi <= r_step[0];
            if (r_prod_vld) begin
                r_acc <= r_acc + w_addend;
            end
        end
    end

    assign o_done = r_done;
    assign o_inc  = r_acc[qas_pkg::ACC_W-1:qas_pkg::RND_SHIFT];

endmodule

FILE: rtl/qas_checker.sv
// port-level checks for the quick advection stencil top level
module qas_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_result_strobe,
    input qas_pkg::t_result o_result
);

    // every result follows a command that kept the block busy
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result strobe without a command in progress");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("busy still high while the result is shown");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.index_error) |->
            (o_result.result_value == '0 && !o_result.saturated))
        else $error("index error item carries data");

endmodule

bind quick_advection_stencil_2d qas_checker u_qas_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_result        (o_result)
);
